// File: hw/rtl/substring_search_macros.svh
// Assertion macros used by the substring search RTL.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SUBSTRING_SEARCH_MACROS_SVH
`define SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SS_ASSERT_IMP(lbl, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SS_ASSERT_NXT(lbl, pre, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error(msg);

`endif

// File: hw/rtl/ss_pkg.sv
package ss_pkg;

    // Register indexes on the configuration port.
    localparam logic REG_NEEDLE_BYTES  = 1'b0;
    localparam logic REG_NEEDLE_LENGTH = 1'b1;

    // Character that ends a string.
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Offset counter: width fixed by the result field, and the index at which
    // bytes stop being searched.
    localparam int          CNT_W        = 16;
    localparam logic [15:0] MAX_HAYSTACK = 16'd65535;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte as it waits in the queue.
    typedef struct packed {
        logic       term;
        logic [7:0] chr;
    } ss_item_t;

    // Head of the queue as seen by the back part.
    typedef struct packed {
        logic     valid;
        ss_item_t item;
    } ss_qhead_t;

    // What the back part did with the head this cycle.
    typedef struct packed {
        logic pop;
        logic term_pop;
    } ss_bk_status_t;

endpackage

// File: hw/rtl/ss_front.sv
module ss_front
    import ss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_in,
    input  ss_bk_status_t bk_status,
    output ss_qhead_t     qhead
);

    ss_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 push;
    ss_item_t             item_in;

    // The input stalls only when the queue is full.
    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;

    // Classify the incoming byte.
    assign item_in.term = (char_in == CHAR_NUL);
    assign item_in.chr  = char_in;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bk_status.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bk_status.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && bk_status.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign qhead.valid = (count_reg != '0);
    assign qhead.item  = entry_reg[rd_ptr_reg];

endmodule

// File: hw/rtl/ss_back.sv
module ss_back
    import ss_pkg::*;
#(
    parameter int MAX_NEEDLE = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      needle_bytes,
    input  logic [3:0]       needle_length,
    input  ss_qhead_t        qhead,
    output ss_bk_status_t    bk_status,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             found,
    output logic [CNT_W-1:0] match_offset,
    output logic             overflow
);

    localparam int         WIN_W    = 8 * MAX_NEEDLE;
    localparam int         LEN_W    = $clog2(MAX_NEEDLE + 1);
    localparam logic [3:0] MAX_LEN4 = 4'(MAX_NEEDLE);

    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic [CNT_W-1:0] count_reg;
    logic             match_reg;
    logic [CNT_W-1:0] first_reg;
    logic             sat_reg;

    logic             out_valid_reg;
    logic             found_reg;
    logic [CNT_W-1:0] offset_reg;
    logic             overflow_reg;

    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] eff_len;
    logic [MAX_NEEDLE:0] hit;
    logic             out_free;
    logic             pop;
    logic             term_pop;
    logic             byte_pop;
    logic             count_full;
    logic             can_search;
    logic [CNT_W-1:0] len_m1;

    // Effective needle length: capped, and cut at the first zero byte.
    always_comb
    begin
        lim = (needle_length > MAX_LEN4) ? LEN_W'(MAX_NEEDLE) : LEN_W'(needle_length);
        eff_len = lim;
        for (int k = MAX_NEEDLE - 1; k >= 0; k--)
        begin
            if ((LEN_W'(k) < lim) && (needle_bytes[8*k +: 8] == CHAR_NUL))
            begin
                eff_len = LEN_W'(k);
            end
        end
    end

    // Handshake with the queue and the output register.
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = qhead.valid && (!qhead.item.term || out_free);
    assign term_pop = pop && qhead.item.term;
    assign byte_pop = pop && !qhead.item.term;

    assign bk_status.pop      = pop;
    assign bk_status.term_pop = term_pop;

    // Window with the new byte shifted in at the top.
    assign window_next = (WIN_W'(qhead.item.chr) << (WIN_W - 8)) | (window_reg >> 8);

    // Parallel compare of the newest bytes against every needle length.
    always_comb
    begin
        hit[0] = 1'b0;
        for (int l = 1; l <= MAX_NEEDLE; l++)
        begin
            hit[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (window_next[8*(MAX_NEEDLE-l+k) +: 8] != needle_bytes[8*k +: 8])
                begin
                    hit[l] = 1'b0;
                end
            end
        end
    end

    assign len_m1     = CNT_W'(eff_len) - 1'b1;
    assign count_full = (count_reg >= MAX_HAYSTACK);
    assign can_search = (eff_len != '0) && !match_reg && !sat_reg && (count_reg >= len_m1);

    // Per-string search state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            match_reg  <= 1'b0;
            first_reg  <= '0;
            sat_reg    <= 1'b0;
        end
        else if (term_pop)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            match_reg  <= 1'b0;
            first_reg  <= '0;
            sat_reg    <= 1'b0;
        end
        else if (byte_pop)
        begin
            window_reg <= window_next;
            if (count_full)
            begin
                if (!match_reg)
                begin
                    sat_reg <= 1'b1;
                end
            end
            else
            begin
                if (can_search && hit[eff_len])
                begin
                    match_reg <= 1'b1;
                    first_reg <= count_reg - len_m1;
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Result register, loaded on the terminator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (term_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (term_pop)
        begin
            if (eff_len == '0)
            begin
                found_reg    <= 1'b1;
                offset_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            else if (match_reg)
            begin
                found_reg    <= 1'b1;
                offset_reg   <= first_reg;
                overflow_reg <= 1'b0;
            end
            else
            begin
                found_reg    <= 1'b0;
                offset_reg   <= '0;
                overflow_reg <= sat_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;
    assign overflow     = overflow_reg;

endmodule

// File: hw/rtl/substring_search.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   char_in (8)
// result    out        out_valid / out_stall found, match_offset (16), overflow
// config    in         cfg_write             cfg_index (1), cfg_data (64)
//
// One byte is taken per cycle while the queue is not full; the rate is set
// by the combinational window compare in the back part, which retires one
// queued byte each clock unless a terminator meets a stalled result. Results
// pass the queue, then the output register; the next string may follow at once.
// Reset clears the needle, the per-string state, the queue and the result.
// A stalled result holds the back part only when a further terminator
// reaches it; the two-entry queue absorbs the input meanwhile.
`include "substring_search_macros.svh"

module substring_search
    import ss_pkg::*;
#(
    parameter int MAX_NEEDLE = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       char_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             found,
    output logic [CNT_W-1:0] match_offset,
    output logic             overflow
);

    logic [63:0]   needle_bytes_reg;
    logic [3:0]    needle_length_reg;
    ss_qhead_t     qhead;
    ss_bk_status_t bk_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_bytes_reg  <= '0;
            needle_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NEEDLE_BYTES:  needle_bytes_reg  <= cfg_data;
                REG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[3:0];
                default:           needle_bytes_reg  <= needle_bytes_reg;
            endcase
        end
    end

    // Front part: takes and classifies bytes into the queue.
    ss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .bk_status (bk_status),
        .qhead     (qhead)
    );

    // Back part: window compare, offset tracking and result register.
    ss_back #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .needle_bytes  (needle_bytes_reg),
        .needle_length (needle_length_reg),
        .qhead         (qhead),
        .bk_status     (bk_status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_offset  (match_offset),
        .overflow      (overflow)
    );

    // A found needle never reports overflow.
    `SS_ASSERT_IMP(a_found_no_ovf, out_valid, !(found && overflow), "found with overflow")
    // A miss always reports offset zero.
    `SS_ASSERT_IMP(a_miss_offset, out_valid && !found, match_offset == '0, "miss offset not zero")
    // A terminator taken from the queue shows a result in the next cycle.
    `SS_ASSERT_NXT(a_term_result, bk_status.term_pop, out_valid, "terminator result lost")
    // The back part only pops what the queue holds.
    `SS_ASSERT_IMP(a_pop_valid, bk_status.pop, qhead.valid, "pop from empty queue")

endmodule
